@@ rtl/rlb_pkg.sv @@
// Shared constants and types for the RGB layer blender.
package rlb_pkg;

    // Width of one color channel
    localparam int CHAN_W = 8;

    // Largest channel value; also the blend weight complement base
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Compositing modes
    localparam logic [1:0] KIND_COPY      = 2'd0;
    localparam logic [1:0] KIND_BLEND     = 2'd1;
    localparam logic [1:0] KIND_ADD       = 2'd2;
    localparam logic [1:0] KIND_ADD_BLEND = 2'd3;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [1:0]        kind_t;

endpackage

@@ rtl/rlb_chan.sv @@
// One color channel of the compositor: saturating add, alpha blend, mode select.
module rlb_chan
(
    input  rlb_pkg::kind_t kind,
    input  rlb_pkg::chan_t src,
    input  rlb_pkg::chan_t add,
    input  rlb_pkg::chan_t dst,
    input  rlb_pkg::chan_t alpha,
    output rlb_pkg::chan_t result
);

    logic [rlb_pkg::CHAN_W:0]     sum;
    rlb_pkg::chan_t               sat;
    rlb_pkg::chan_t               blend_src;
    rlb_pkg::chan_t               inv_alpha;
    logic [2*rlb_pkg::CHAN_W-1:0] prod_s;
    logic [2*rlb_pkg::CHAN_W-1:0] prod_d;
    logic [2*rlb_pkg::CHAN_W-1:0] mix;

    // Saturating add of source and additive layer
    assign sum = {1'b0, src} + {1'b0, add};
    assign sat = sum[rlb_pkg::CHAN_W] ? rlb_pkg::CHAN_MAX : sum[rlb_pkg::CHAN_W-1:0];

    // Blend: (s*a + d*(255-a)) >> 8; the sum never exceeds 16 bits
    assign blend_src = (kind == rlb_pkg::KIND_ADD_BLEND) ? sat : src;
    assign inv_alpha = rlb_pkg::CHAN_MAX - alpha;
    assign prod_s    = {{rlb_pkg::CHAN_W{1'b0}}, blend_src} * {{rlb_pkg::CHAN_W{1'b0}}, alpha};
    assign prod_d    = {{rlb_pkg::CHAN_W{1'b0}}, dst} * {{rlb_pkg::CHAN_W{1'b0}}, inv_alpha};
    assign mix       = prod_s + prod_d;

    // Mode select
    always_comb
    begin
        case (kind)
            rlb_pkg::KIND_COPY:      result = src;
            rlb_pkg::KIND_BLEND:     result = mix[2*rlb_pkg::CHAN_W-1:rlb_pkg::CHAN_W];
            rlb_pkg::KIND_ADD:       result = sat;
            rlb_pkg::KIND_ADD_BLEND: result = mix[2*rlb_pkg::CHAN_W-1:rlb_pkg::CHAN_W];
            default:                 result = src;
        endcase
    end

endmodule

@@ rtl/rgb_layer_blend_saturating_add.sv @@
// Usage notes:
// Per-pixel layer compositor. The input channel carries one word per pixel:
// mode (kind), source RGBA, additive RGB and current destination RGBA. The
// output channel carries the new destination RGBA.
// Both channels use valid/stall; a word moves on a rising edge with valid
// high and stall low.
// From input acceptance to output valid, a word passes the input register,
// then one pass through the channel multipliers into the result register.
// Throughput: one pixel per clock; a new word is taken every cycle while the
// result register drains or is free.
// When the receiver stalls, the result register holds its word; the input
// register takes one more word, and in_stall is high in every cycle where
// it holds a word behind a stalled result. No words are dropped or repeated.
// Reset (rst_n low, asynchronous) empties both stages; no clearing pass.
// The critical path is a 9-bit saturating add, one 8x8 multiply pair and a
// 16-bit add.
module rgb_layer_blend_saturating_add
(
    input  logic           clk,
    input  logic           rst_n,

    input  logic           in_valid,
    output logic           in_stall,
    input  rlb_pkg::kind_t kind,
    input  rlb_pkg::chan_t src_red,
    input  rlb_pkg::chan_t src_green,
    input  rlb_pkg::chan_t src_blue,
    input  rlb_pkg::chan_t src_alpha,
    input  rlb_pkg::chan_t add_red,
    input  rlb_pkg::chan_t add_green,
    input  rlb_pkg::chan_t add_blue,
    input  rlb_pkg::chan_t dst_red,
    input  rlb_pkg::chan_t dst_green,
    input  rlb_pkg::chan_t dst_blue,
    input  rlb_pkg::chan_t dst_alpha,

    output logic           out_valid,
    input  logic           out_stall,
    output rlb_pkg::chan_t out_red,
    output rlb_pkg::chan_t out_green,
    output rlb_pkg::chan_t out_blue,
    output rlb_pkg::chan_t out_alpha
);

    // Input stage registers
    logic           s1_valid_reg;
    logic           s1_valid_next;
    rlb_pkg::kind_t s1_kind_reg;
    rlb_pkg::chan_t s1_src_r_reg, s1_src_g_reg, s1_src_b_reg, s1_src_a_reg;
    rlb_pkg::chan_t s1_add_r_reg, s1_add_g_reg, s1_add_b_reg;
    rlb_pkg::chan_t s1_dst_r_reg, s1_dst_g_reg, s1_dst_b_reg, s1_dst_a_reg;

    // Result stage registers
    logic           out_valid_reg;
    logic           out_valid_next;
    rlb_pkg::chan_t out_r_reg, out_g_reg, out_b_reg, out_a_reg;

    rlb_pkg::chan_t res_r, res_g, res_b, res_a;
    logic           out_free;
    logic           s1_load;
    logic           s1_move;

    // Flow control: result register can load when empty or draining
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign s1_load  = in_valid && !in_stall;

    assign s1_valid_next  = s1_load || (s1_valid_reg && !out_free);
    assign out_valid_next = s1_move || (out_valid_reg && out_stall);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input word capture
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_kind_reg  <= kind;
            s1_src_r_reg <= src_red;
            s1_src_g_reg <= src_green;
            s1_src_b_reg <= src_blue;
            s1_src_a_reg <= src_alpha;
            s1_add_r_reg <= add_red;
            s1_add_g_reg <= add_green;
            s1_add_b_reg <= add_blue;
            s1_dst_r_reg <= dst_red;
            s1_dst_g_reg <= dst_green;
            s1_dst_b_reg <= dst_blue;
            s1_dst_a_reg <= dst_alpha;
        end
    end

    // Per-channel compositing
    rlb_chan u_chan_r
    (
        .kind   (s1_kind_reg),
        .src    (s1_src_r_reg),
        .add    (s1_add_r_reg),
        .dst    (s1_dst_r_reg),
        .alpha  (s1_src_a_reg),
        .result (res_r)
    );

    rlb_chan u_chan_g
    (
        .kind   (s1_kind_reg),
        .src    (s1_src_g_reg),
        .add    (s1_add_g_reg),
        .dst    (s1_dst_g_reg),
        .alpha  (s1_src_a_reg),
        .result (res_g)
    );

    rlb_chan u_chan_b
    (
        .kind   (s1_kind_reg),
        .src    (s1_src_b_reg),
        .add    (s1_add_b_reg),
        .dst    (s1_dst_b_reg),
        .alpha  (s1_src_a_reg),
        .result (res_b)
    );

    // Alpha: source in copy mode, destination otherwise
    assign res_a = (s1_kind_reg == rlb_pkg::KIND_COPY) ? s1_src_a_reg : s1_dst_a_reg;

    // Result word capture
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_r_reg <= res_r;
            out_g_reg <= res_g;
            out_b_reg <= res_b;
            out_a_reg <= res_a;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_r_reg;
    assign out_green = out_g_reg;
    assign out_blue  = out_b_reg;
    assign out_alpha = out_a_reg;

`ifndef NO_ASSERTIONS
    // Input stalls only when a word is parked in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("in_stall without a held input word");

    // A held input word moves into a free result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !(out_valid && out_stall)) |=> out_valid)
        else $error("input word failed to reach result register");

    // Output never becomes valid without a word in the input stage before
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid_reg))
        else $error("output valid without source word");

    // Copy mode passes the source alpha straight through
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_kind_reg == rlb_pkg::KIND_COPY) |=> out_alpha == $past(s1_src_a_reg))
        else $error("copy mode alpha mismatch");
`endif

endmodule

@@ dv/rgb_layer_blend_saturating_add_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the RGB layer blender: directed corners, backpressure, random streams.
module rgb_layer_blend_saturating_add_test;

    // One input word: mode plus source, additive and destination pixels
    typedef struct packed {
        rlb_pkg::kind_t kind;
        rlb_pkg::chan_t src_r;
        rlb_pkg::chan_t src_g;
        rlb_pkg::chan_t src_b;
        rlb_pkg::chan_t src_a;
        rlb_pkg::chan_t add_r;
        rlb_pkg::chan_t add_g;
        rlb_pkg::chan_t add_b;
        rlb_pkg::chan_t dst_r;
        rlb_pkg::chan_t dst_g;
        rlb_pkg::chan_t dst_b;
        rlb_pkg::chan_t dst_a;
    } pixel_t;

    // One output word: new destination pixel
    typedef struct packed {
        rlb_pkg::chan_t r;
        rlb_pkg::chan_t g;
        rlb_pkg::chan_t b;
        rlb_pkg::chan_t a;
    } rgba_t;

    // Receiver stall patterns
    typedef enum int { RX_NEVER, RX_RANDOM, RX_PERIODIC, RX_HEAVY } rx_pattern_t;

    localparam int IDLE_LIMIT   = 1000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    rlb_pkg::kind_t kind;
    rlb_pkg::chan_t src_red, src_green, src_blue, src_alpha;
    rlb_pkg::chan_t add_red, add_green, add_blue;
    rlb_pkg::chan_t dst_red, dst_green, dst_blue, dst_alpha;
    logic           out_valid;
    logic           out_stall;
    rlb_pkg::chan_t out_red, out_green, out_blue, out_alpha;

    rgba_t       expected_rgba_q[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    rx_pattern_t rx_pattern  = RX_NEVER;
    int          hold_request = 0;
    int          hold_left    = 0;
    int          rx_phase     = 0;

    rgb_layer_blend_saturating_add dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .src_red   (src_red),
        .src_green (src_green),
        .src_blue  (src_blue),
        .src_alpha (src_alpha),
        .add_red   (add_red),
        .add_green (add_green),
        .add_blue  (add_blue),
        .dst_red   (dst_red),
        .dst_green (dst_green),
        .dst_blue  (dst_blue),
        .dst_alpha (dst_alpha),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Channel sum clamped at full scale
    function automatic rlb_pkg::chan_t clamp_sum(rlb_pkg::chan_t a, rlb_pkg::chan_t b);
        int t;
        t = int'(a) + int'(b);
        return (t > int'(rlb_pkg::CHAN_MAX)) ? rlb_pkg::CHAN_MAX : rlb_pkg::chan_t'(t);
    endfunction

    // Weighted mix (s*a + d*(255-a)) >> 8; full weight tops out at 254
    function automatic rlb_pkg::chan_t weigh(rlb_pkg::chan_t s, rlb_pkg::chan_t d,
                                             rlb_pkg::chan_t a);
        int t;
        t = int'(s) * int'(a) + int'(d) * (int'(rlb_pkg::CHAN_MAX) - int'(a));
        return rlb_pkg::chan_t'(t >> 8);
    endfunction

    // Expected new destination pixel for one input word
    function automatic rgba_t composite(pixel_t p);
        rgba_t o;
        o.a = p.dst_a;
        case (p.kind)
            rlb_pkg::KIND_COPY:
            begin
                o.r = p.src_r;
                o.g = p.src_g;
                o.b = p.src_b;
                o.a = p.src_a;
            end
            rlb_pkg::KIND_BLEND:
            begin
                o.r = weigh(p.src_r, p.dst_r, p.src_a);
                o.g = weigh(p.src_g, p.dst_g, p.src_a);
                o.b = weigh(p.src_b, p.dst_b, p.src_a);
            end
            rlb_pkg::KIND_ADD:
            begin
                o.r = clamp_sum(p.src_r, p.add_r);
                o.g = clamp_sum(p.src_g, p.add_g);
                o.b = clamp_sum(p.src_b, p.add_b);
            end
            default:
            begin
                o.r = weigh(clamp_sum(p.src_r, p.add_r), p.dst_r, p.src_a);
                o.g = weigh(clamp_sum(p.src_g, p.add_g), p.dst_g, p.src_a);
                o.b = weigh(clamp_sum(p.src_b, p.add_b), p.dst_b, p.src_a);
            end
        endcase
        return o;
    endfunction

    function automatic pixel_t make_pixel(rlb_pkg::kind_t k,
                                          rlb_pkg::chan_t sr, rlb_pkg::chan_t sg,
                                          rlb_pkg::chan_t sb, rlb_pkg::chan_t sa,
                                          rlb_pkg::chan_t ar, rlb_pkg::chan_t ag,
                                          rlb_pkg::chan_t ab,
                                          rlb_pkg::chan_t dr, rlb_pkg::chan_t dg,
                                          rlb_pkg::chan_t db, rlb_pkg::chan_t da);
        pixel_t p;
        p.kind  = k;
        p.src_r = sr;
        p.src_g = sg;
        p.src_b = sb;
        p.src_a = sa;
        p.add_r = ar;
        p.add_g = ag;
        p.add_b = ab;
        p.dst_r = dr;
        p.dst_g = dg;
        p.dst_b = db;
        p.dst_a = da;
        return p;
    endfunction

    // Channel value biased toward the extremes
    function automatic rlb_pkg::chan_t rand_chan();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return rlb_pkg::CHAN_MAX;
            default: return rlb_pkg::chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        return make_pixel(rlb_pkg::kind_t'($urandom_range(0, 3)),
                          rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                          rand_chan(), rand_chan(), rand_chan(),
                          rand_chan(), rand_chan(), rand_chan(), rand_chan());
    endfunction

    // Offer one word at the falling edge and hold it until accepted
    task automatic send_pixel(input pixel_t p);
        @(negedge clk);
        in_valid  <= 1'b1;
        kind      <= p.kind;
        src_red   <= p.src_r;
        src_green <= p.src_g;
        src_blue  <= p.src_b;
        src_alpha <= p.src_a;
        add_red   <= p.add_r;
        add_green <= p.add_g;
        add_blue  <= p.add_b;
        dst_red   <= p.dst_r;
        dst_green <= p.dst_g;
        dst_blue  <= p.dst_b;
        dst_alpha <= p.dst_a;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic pause_input(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Extremes, every mode, full-weight blend, saturation, unused additive
    task automatic test_mode_corners();
        rlb_pkg::kind_t k;
        rx_pattern = RX_RANDOM;
        for (int m = 0; m < 4; m++)
        begin
            k = rlb_pkg::kind_t'(m);
            send_pixel(make_pixel(k, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
            send_pixel(make_pixel(k, 255, 255, 255, 255, 255, 255, 255,
                                  255, 255, 255, 255));
            send_pixel(make_pixel(k, 255, 255, 255, 255, 0, 0, 0, 0, 0, 0, 8'h42));
            send_pixel(make_pixel(k, 255, 128, 1, 0, 255, 255, 255,
                                  8'h5A, 8'hA5, 8'h3C, 8'hC3));
            send_pixel(make_pixel(k, 200, 100, 1, 128, 100, 155, 0,
                                  17, 0, 255, 8'h81));
        end
    endtask

    // Receiver holds off for a long stretch while words keep coming
    task automatic test_backpressure(input int count);
        rx_pattern   = RX_NEVER;
        hold_request = HOLD_CYCLES;
        repeat (count)
            send_pixel(random_pixel());
    endtask

    // Random words in bursts with random gaps
    task automatic test_random_stream(input int count, input rx_pattern_t pat,
                                      input int max_gap);
        int sent;
        int burst;
        rx_pattern = pat;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                send_pixel(random_pixel());
                sent++;
            end
            if (max_gap > 0 && $urandom_range(0, 2) != 0)
                pause_input($urandom_range(1, max_gap));
        end
    endtask

    task automatic check_chan(input string field, input rlb_pkg::chan_t want,
                              input rlb_pkg::chan_t got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    // Receiver stall generator, with a long hold on request
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            case (rx_pattern)
                RX_NEVER:    out_stall <= 1'b0;
                RX_RANDOM:   out_stall <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: out_stall <= ((rx_phase % 7) < 3);
                default:     out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
        rx_phase++;
    end

    // Predict on each accepted input word, check each accepted output word
    always @(posedge clk)
    begin
        pixel_t seen;
        rgba_t  want;
        if (rst_n && in_valid && !in_stall)
        begin
            seen = make_pixel(kind, src_red, src_green, src_blue, src_alpha,
                              add_red, add_green, add_blue,
                              dst_red, dst_green, dst_blue, dst_alpha);
            expected_rgba_q.push_back(composite(seen));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rgba_q.size() == 0)
            begin
                $display("%0t: output word with none expected, actual %h %h %h %h",
                         $time, out_red, out_green, out_blue, out_alpha);
                error_count++;
            end
            else
            begin
                want = expected_rgba_q.pop_front();
                check_chan("out_red",   want.r, out_red);
                check_chan("out_green", want.g, out_green);
                check_chan("out_blue",  want.b, out_blue);
                check_chan("out_alpha", want.a, out_alpha);
            end
        end
    end

    // Watchdog: too long with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d words outstanding",
                     $time, expected_rgba_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_stall = 1'b0;
        kind      = rlb_pkg::KIND_COPY;
        src_red   = '0;
        src_green = '0;
        src_blue  = '0;
        src_alpha = '0;
        add_red   = '0;
        add_green = '0;
        add_blue  = '0;
        dst_red   = '0;
        dst_green = '0;
        dst_blue  = '0;
        dst_alpha = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_mode_corners();
        test_backpressure(40);
        test_random_stream(175, RX_NEVER, 0);
        test_random_stream(175, RX_RANDOM, 6);
        test_random_stream(175, RX_PERIODIC, 3);
        test_random_stream(175, RX_HEAVY, 8);

        // Drain
        rx_pattern = RX_NEVER;
        pause_input(1);
        while (expected_rgba_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_rgba_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
